>>> design/amb3_pkg.sv
// Shared types, constants and helper functions of the third-order ambisonic panner.
`timescale 1ns / 1ps
`default_nettype none
package amb3_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int ANGLE_BITS_DEF  = 16;

  localparam int NCH    = 7;
  localparam int AW     = $clog2(NCH);
  localparam int WB     = 40;
  localparam int TW     = 48;
  localparam int RAMP_W = 25;
  localparam int SDIV_N = 6;
  localparam int CDIV_N = 7;

  localparam logic [RAMP_W-1:0] RAMP_RESET     = 25'd16384;
  localparam logic [63:0]       ONE_Q62        = 64'h4000_0000_0000_0000;
  localparam logic [63:0]       PI4_Q62        = 64'h3243_F6A8_885A_308D;
  localparam logic [WB-1:0]     HALF_SQRT2_Q38 = 40'd194368031998;

  localparam logic signed [63:0] WMAX64 = (64'sd1 <<< (WB - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;

  localparam logic [AW-1:0] CH_W = 3'd0;
  localparam logic [AW-1:0] CH_X = 3'd1;
  localparam logic [AW-1:0] CH_Y = 3'd2;
  localparam logic [AW-1:0] CH_U = 3'd3;
  localparam logic [AW-1:0] CH_V = 3'd4;
  localparam logic [AW-1:0] CH_P = 3'd5;
  localparam logic [AW-1:0] CH_Q = 3'd6;

  // Rounding shift applied by the shared multiplier.
  typedef enum logic [1:0] {SHF_ANG, SHF_62, SHF_38, SHF_24} shf_t;

  typedef enum logic [4:0] {
    S_IDLE, S_T, S_T2, S_SMUL, S_SDIV, S_SN, S_XY, S_X2, S_Y2, S_VXY,
    S_P, S_Q, S_SRD, S_SMC, S_RD, S_UPD, S_MW, S_EMIT
  } st_t;

  typedef struct packed {
    logic signed [WB-1:0] cw;
    logic signed [WB-1:0] step;
  } wentry_t;

  // Divisors of the nested Taylor series for sine and cosine.
  function automatic logic [7:0] div_const(input logic cos_ph, input logic [2:0] i);
    logic [7:0] d;
    d = 8'd2;
    if (cos_ph) begin
      unique case (i)
        3'd0: d = 8'd182;
        3'd1: d = 8'd132;
        3'd2: d = 8'd90;
        3'd3: d = 8'd56;
        3'd4: d = 8'd30;
        3'd5: d = 8'd12;
        default: d = 8'd2;
      endcase
    end else begin
      unique case (i)
        3'd0: d = 8'd156;
        3'd1: d = 8'd110;
        3'd2: d = 8'd72;
        3'd3: d = 8'd42;
        3'd4: d = 8'd20;
        default: d = 8'd6;
      endcase
    end
    return d;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [WB-1:0] sat_w(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > WMAX64) begin
      r = WMAX64;
    end else if (v < WMIN64) begin
      r = WMIN64;
    end
    return WB'(r);
  endfunction

endpackage
`default_nettype wire

>>> design/amb3_mul.sv
// Shared multi-cycle 64 x 64 multiplier with round-to-nearest right shift and sign.
`timescale 1ns / 1ps
`default_nettype none
module amb3_mul #(
  parameter int ANGLE_BITS = amb3_pkg::ANGLE_BITS_DEF
) (
  input  wire                logic  clk,
  input  wire                logic  rst_n,
  input  wire                logic  start,
  input  wire                logic [63:0] a,
  input  wire                logic [63:0] b,
  input  wire                logic  neg,
  input  wire amb3_pkg::shf_t       shf,
  output logic               done,
  output logic [63:0]        res
);
  import amb3_pkg::*;

  localparam int SH_ANG = ANGLE_BITS - 3;

  logic [63:0]  a_r, b_r, prod_r, res_r;
  logic         neg_r, busy_r, done_r;
  shf_t         shf_r;
  logic [2:0]   cnt_r;
  logic [1:0]   off_r;
  logic [127:0] acc_r, rnd, shd;
  logic [31:0]  a_part, b_part;
  logic [63:0]  mag;

  // Rounding offset of half an output LSB preloads the accumulator.
  always_comb begin
    unique case (shf)
      SHF_ANG: rnd = 128'd1 << (SH_ANG - 1);
      SHF_62:  rnd = 128'd1 << 61;
      SHF_38:  rnd = 128'd1 << 37;
      default: rnd = 128'd1 << 23;
    endcase
  end

  always_comb begin
    unique case (shf_r)
      SHF_ANG: shd = acc_r >> SH_ANG;
      SHF_62:  shd = acc_r >> 62;
      SHF_38:  shd = acc_r >> 38;
      default: shd = acc_r >> 24;
    endcase
  end

  assign a_part = cnt_r[0] ? a_r[63:32] : a_r[31:0];
  assign b_part = cnt_r[1] ? b_r[63:32] : b_r[31:0];
  assign mag    = shd[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      neg_r <= neg;
      shf_r <= shf;
      acc_r <= rnd;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) begin
        prod_r <= a_part * b_part;
        off_r  <= 2'(cnt_r[0]) + 2'(cnt_r[1]);
      end
      if (cnt_r != 3'd0 && cnt_r < 3'd5) begin
        acc_r <= acc_r + ({64'd0, prod_r} << {off_r, 5'd0});
      end
      if (cnt_r == 3'd5) begin
        res_r <= neg_r ? 64'(-mag) : mag;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
endmodule
`default_nettype wire

>>> design/amb3_div.sv
// Divider of a 64-bit value by a small constant, eight quotient bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module amb3_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [7:0]  divisor,
  output logic             done,
  output logic [63:0]      quot
);
  import amb3_pkg::*;

  logic [63:0] num_r, quot_r;
  logic [7:0]  den_r, rem_r, rem_c, qb_c;
  logic [8:0]  t9_c;
  logic [2:0]  cnt_r;
  logic        busy_r, done_r;

  always_comb begin
    rem_c = rem_r;
    qb_c  = '0;
    t9_c  = '0;
    for (int j = 0; j < 8; j++) begin
      t9_c = {rem_c, num_r[63-j]};
      if (t9_c >= {1'b0, den_r}) begin
        rem_c      = 8'(t9_c - {1'b0, den_r});
        qb_c[7-j]  = 1'b1;
      end else begin
        rem_c = t9_c[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r  <= num_r << 8;
      rem_r  <= rem_c;
      quot_r <= {quot_r[55:0], qb_c};
    end
  end

  assign done = done_r;
  assign quot = quot_r;
endmodule
`default_nettype wire

>>> design/amb3_wmem.sv
// Weight memory: current weight and step of each channel, registered read.
`timescale 1ns / 1ps
`default_nettype none
module amb3_wmem (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [amb3_pkg::AW-1:0]  wr_addr,
  input  wire amb3_pkg::wentry_t        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [amb3_pkg::AW-1:0]  rd_addr,
  output amb3_pkg::wentry_t             rd_data
);
  import amb3_pkg::*;

  wentry_t        mem [NCH];
  wentry_t        rd_q_r;
  logic [NCH-1:0] valid_r;
  logic           rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Entries never written since reset read as zero weight and zero step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;
endmodule
`default_nettype wire

>>> design/ambisonic_3rd_order_panner.sv
// Top level of the horizontal third-order ambisonic panner.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one request per mono sample, weights it into the seven horizontal
// third-order channels W, X, Y, U, V, P and Q and adds each weighted sample, saturated,
// to the bus value that came with it. The weights sit in a small synchronous memory,
// one entry per channel holding the current weight and its per-sample step; each
// sample reads an entry, steps the weight, writes it back and multiplies. A request
// flagged as a chunk start first derives new targets from the azimuth (octant folding
// and nested Taylor series for sine and cosine) and writes fresh steps equal to the
// distance to the target times ramp_step, shifted right by 24 bits. All products but
// the scalings by three go through one shared 32 x 32 bit multiplier that builds each
// 64 x 64 bit product in four partial products, and the series divisions go through a
// divider that yields eight quotient bits per cycle. A plain sample's time is set by
// its seven multiplications, a chunk start's mostly by the thirteen series steps. One
// request is worked on at a time; a finished result waits in the output register
// while the next request is taken in. The user must write ramp_step through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block itself does not enforce it.
module ambisonic_3rd_order_panner #(
  parameter int SAMPLE_BITS = amb3_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_BITS  = amb3_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [amb3_pkg::RAMP_W-1:0]   cfg_wr_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // azimuth, sample, bus_w, bus_x, bus_y, bus_u, bus_v, bus_p, bus_q (lowest first)
  input  wire logic [((ANGLE_BITS + 8*SAMPLE_BITS + 7)/8)*8-1:0] in_tdata,
  // chunk_start
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // mix_w, mix_x, mix_y, mix_u, mix_v, mix_p, mix_q (lowest first)
  output logic [((7*SAMPLE_BITS + 7)/8)*8-1:0] out_tdata
);
  import amb3_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int SH    = ANGLE_BITS - 3;
  localparam int OUT_W = ((7*SAMPLE_BITS + 7)/8)*8;
  localparam logic signed [SB+2:0] OMAX = (SB+3)'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SB+2:0] OMIN = -OMAX - 1;

  // Sequencer state.
  st_t            state_r, state_nxt;
  logic [AW-1:0]  k_r;
  logic [2:0]     i_r;
  logic           cos_r, pend_r, out_tvalid_r;
  logic [RAMP_W-1:0] ramp_r;

  // Captured request and working values.
  logic [2:0]              oct_r;
  logic [SH:0]             rf_r;
  logic signed [SB-1:0]    smp_r;
  logic signed [SB-1:0]    bus_r [NCH];
  logic signed [SB-1:0]    mix_r [NCH];
  logic [63:0]             t_r, t2_r, p_r, acc_r, sn_r;
  logic signed [WB-1:0]    x_r, y_r, x2_r, y2_r, xy_r, cwn_r;
  logic signed [TW-1:0]    tp_r, tq_r;
  logic [OUT_W-1:0]        out_tdata_r, out_nxt;

  // Unit and memory hookup.
  logic        mul_start, mul_neg, mul_done;
  logic [63:0] mul_a, mul_b, mul_res;
  shf_t        mul_shf;
  logic        div_start, div_done;
  logic [63:0] div_num, div_quot;
  logic [7:0]  div_den;
  logic        mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  wentry_t     mem_wr_data, mem_rd;

  logic        accept, k_last, ser_last, swap, cneg, sneg, emit_go;
  logic [2:0]  az_oct;
  logic [SH-1:0] az_r;
  logic [63:0] cm, sm, xr, yr;
  logic signed [TW-1:0] tgt, dv, pv, qv;
  logic signed [WB:0]   cw_sum;
  logic signed [SB+2:0] mix_sum;
  logic signed [63:0]   res_s;

  assign accept   = in_tvalid && in_tready;
  assign k_last   = (k_r == CH_Q);
  assign ser_last = cos_r ? (i_r == 3'(CDIV_N - 1)) : (i_r == 3'(SDIV_N - 1));
  assign emit_go  = !out_tvalid_r || out_tready;
  assign res_s    = $signed(mul_res);

  // Octant folding of the azimuth: odd octants mirror the angle within the octant.
  assign az_oct = in_tdata[ANGLE_BITS-1 -: 3];
  assign az_r   = in_tdata[SH-1:0];

  // Mapping of the first-octant sine and cosine back onto the full circle.
  assign swap = (oct_r == 3'd1) || (oct_r == 3'd2) || (oct_r == 3'd5) || (oct_r == 3'd6);
  assign cneg = (oct_r >= 3'd2) && (oct_r <= 3'd5);
  assign sneg = (oct_r >= 3'd4);
  assign cm   = swap ? sn_r : acc_r;
  assign sm   = swap ? acc_r : sn_r;
  assign xr   = (cm + 64'h80_0000) >> 24;
  assign yr   = (sm + 64'h80_0000) >> 24;

  // Operands of the two cubic harmonics.
  assign pv = TW'(x2_r) - 3 * TW'(y2_r);
  assign qv = 3 * TW'(x2_r) - TW'(y2_r);

  // Target weight of the channel being processed.
  always_comb begin
    unique case (k_r)
      CH_W:    tgt = TW'($signed(HALF_SQRT2_Q38));
      CH_X:    tgt = TW'(x_r);
      CH_Y:    tgt = TW'(y_r);
      CH_U:    tgt = TW'(x2_r) - TW'(y2_r);
      CH_V:    tgt = TW'(xy_r) <<< 1;
      CH_P:    tgt = tp_r;
      default: tgt = tq_r;
    endcase
  end

  assign dv      = tgt - TW'(mem_rd.cw);
  assign cw_sum  = (WB+1)'(mem_rd.cw) + (WB+1)'(mem_rd.step);
  assign mix_sum = (SB+3)'(bus_r[k_r]) + (SB+3)'(res_s);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = in_tuser ? S_T : S_RD;
      S_T:     if (mul_done) state_nxt = S_T2;
      S_T2:    if (mul_done) state_nxt = S_SMUL;
      S_SMUL:  if (mul_done) state_nxt = S_SDIV;
      S_SDIV: begin
        if (div_done) begin
          if (ser_last) state_nxt = cos_r ? S_XY : S_SN;
          else          state_nxt = S_SMUL;
        end
      end
      S_SN:    if (mul_done) state_nxt = S_SMUL;
      S_XY:    state_nxt = S_X2;
      S_X2:    if (mul_done) state_nxt = S_Y2;
      S_Y2:    if (mul_done) state_nxt = S_VXY;
      S_VXY:   if (mul_done) state_nxt = S_P;
      S_P:     if (mul_done) state_nxt = S_Q;
      S_Q:     if (mul_done) state_nxt = S_SRD;
      S_SRD:   state_nxt = S_SMC;
      S_SMC:   if (mul_done) state_nxt = k_last ? S_RD : S_SRD;
      S_RD:    state_nxt = S_UPD;
      S_UPD:   state_nxt = S_MW;
      S_MW:    if (mul_done) state_nxt = k_last ? S_EMIT : S_RD;
      S_EMIT:  if (emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer. Each memory entry is read, stepped and written back
  // before the next entry is read, so a read never meets a pending write.
  always_comb begin
    in_tready   = 1'b0;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    mul_neg     = 1'b0;
    mul_shf     = SHF_38;
    div_start   = 1'b0;
    div_num     = p_r;
    div_den     = div_const(cos_r, i_r);
    mem_rd_en   = 1'b0;
    mem_rd_addr = k_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = k_r;
    mem_wr_data = mem_rd;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_T: begin
        mul_start = !pend_r;
        mul_a     = 64'(rf_r);
        mul_b     = PI4_Q62;
        mul_shf   = SHF_ANG;
      end
      S_T2: begin
        mul_start = !pend_r;
        mul_a     = t_r;
        mul_b     = t_r;
        mul_shf   = SHF_62;
      end
      S_SMUL: begin
        mul_start = !pend_r;
        mul_a     = t2_r;
        mul_b     = acc_r;
        mul_shf   = SHF_62;
      end
      S_SDIV: div_start = !pend_r;
      S_SN: begin
        mul_start = !pend_r;
        mul_a     = t_r;
        mul_b     = acc_r;
        mul_shf   = SHF_62;
      end
      S_X2: begin
        mul_start = !pend_r;
        mul_a     = mag64(64'(x_r));
        mul_b     = mag64(64'(x_r));
      end
      S_Y2: begin
        mul_start = !pend_r;
        mul_a     = mag64(64'(y_r));
        mul_b     = mag64(64'(y_r));
      end
      S_VXY: begin
        mul_start = !pend_r;
        mul_a     = mag64(64'(x_r));
        mul_b     = mag64(64'(y_r));
        mul_neg   = x_r[WB-1] ^ y_r[WB-1];
      end
      S_P: begin
        mul_start = !pend_r;
        mul_a     = mag64(64'(pv));
        mul_b     = mag64(64'(x_r));
        mul_neg   = pv[TW-1] ^ x_r[WB-1];
      end
      S_Q: begin
        mul_start = !pend_r;
        mul_a     = mag64(64'(qv));
        mul_b     = mag64(64'(y_r));
        mul_neg   = qv[TW-1] ^ y_r[WB-1];
      end
      S_SRD: mem_rd_en = 1'b1;
      S_SMC: begin
        mul_start        = !pend_r;
        mul_a            = mag64(64'(dv));
        mul_b            = 64'(ramp_r);
        mul_neg          = dv[TW-1];
        mul_shf          = SHF_24;
        mem_wr_en        = mul_done;
        mem_wr_data.cw   = mem_rd.cw;
        mem_wr_data.step = sat_w(res_s);
      end
      S_RD: mem_rd_en = 1'b1;
      S_UPD: begin
        mem_wr_en        = 1'b1;
        mem_wr_data.cw   = sat_w(64'(cw_sum));
        mem_wr_data.step = mem_rd.step;
      end
      S_MW: begin
        mul_start = !pend_r;
        mul_a     = mag64(64'(cwn_r));
        mul_b     = mag64(64'(smp_r));
        mul_neg   = cwn_r[WB-1] ^ smp_r[SB-1];
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      k_r          <= '0;
      i_r          <= '0;
      cos_r        <= 1'b0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      ramp_r       <= RAMP_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        ramp_r <= cfg_wr_data;
      end
      if (mul_start || div_start) begin
        pend_r <= 1'b1;
      end else if (mul_done || div_done) begin
        pend_r <= 1'b0;
      end
      if (accept) begin
        k_r   <= '0;
        i_r   <= '0;
        cos_r <= 1'b0;
      end
      if (state_r == S_SDIV && div_done) begin
        i_r <= i_r + 3'd1;
      end
      if (state_r == S_SN && mul_done) begin
        i_r   <= '0;
        cos_r <= 1'b1;
      end
      if ((state_r == S_SMC || state_r == S_MW) && mul_done) begin
        k_r <= k_last ? '0 : k_r + AW'(1);
      end
      if (state_r == S_EMIT && emit_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Output packing.
  always_comb begin
    out_nxt = '0;
    for (int c = 0; c < NCH; c++) begin
      out_nxt[c*SB +: SB] = mix_r[c];
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      oct_r <= az_oct;
      rf_r  <= az_oct[0] ? ({1'b1, {SH{1'b0}}} - {1'b0, az_r}) : {1'b0, az_r};
      smp_r <= in_tdata[ANGLE_BITS +: SB];
      for (int c = 0; c < NCH; c++) begin
        bus_r[c] <= in_tdata[ANGLE_BITS + SB + c*SB +: SB];
      end
      acc_r <= ONE_Q62;
    end
    unique case (state_r)
      S_T:    if (mul_done) t_r  <= mul_res;
      S_T2:   if (mul_done) t2_r <= mul_res;
      S_SMUL: if (mul_done) p_r  <= mul_res;
      S_SDIV: if (div_done) acc_r <= ONE_Q62 - div_quot;
      S_SN: begin
        if (mul_done) begin
          sn_r  <= mul_res;
          acc_r <= ONE_Q62;
        end
      end
      S_XY: begin
        x_r <= cneg ? -WB'(xr) : WB'(xr);
        y_r <= sneg ? -WB'(yr) : WB'(yr);
      end
      S_X2:  if (mul_done) x2_r <= WB'(res_s);
      S_Y2:  if (mul_done) y2_r <= WB'(res_s);
      S_VXY: if (mul_done) xy_r <= WB'(res_s);
      S_P:   if (mul_done) tp_r <= TW'(res_s);
      S_Q:   if (mul_done) tq_r <= TW'(res_s);
      S_UPD: cwn_r <= sat_w(64'(cw_sum));
      S_MW: begin
        if (mul_done) begin
          if (mix_sum > OMAX)      mix_r[k_r] <= SB'(OMAX);
          else if (mix_sum < OMIN) mix_r[k_r] <= SB'(OMIN);
          else                     mix_r[k_r] <= SB'(mix_sum);
        end
      end
      S_EMIT: if (emit_go) out_tdata_r <= out_nxt;
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  amb3_mul #(.ANGLE_BITS(ANGLE_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .neg   (mul_neg),
    .shf   (mul_shf),
    .done  (mul_done),
    .res   (mul_res)
  );

  amb3_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_quot)
  );

  amb3_wmem u_wmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd)
  );
endmodule
`default_nettype wire

>>> design/amb3_chk.sv
// Port-level checker of the ambisonic panner and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module amb3_chk #(
  parameter int SAMPLE_BITS = amb3_pkg::SAMPLE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [((7*SAMPLE_BITS + 7)/8)*8-1:0] out_tdata
);
  import amb3_pkg::*;

  // One request at a time: taking a request closes the input side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // A new result appears only as the sequencer returns to idle.
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result shown while a request is still in work");

  // Reset leaves the block empty and ready.
  a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
endmodule

bind ambisonic_3rd_order_panner amb3_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_amb3_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
